// File: design/rvr_pkg.sv
`default_nettype none
package rvr_pkg;

  // Field widths of the channels.
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int LANES = 3;

  // Control that travels with each word from stage to stage.
  typedef struct packed {
    logic valid;
    logic three_d;
  } rvr_ctl_t;

endpackage
`default_nettype wire

// File: design/rvr_if.sv
`default_nettype none
interface rvr_in_if;
  import rvr_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_x;
  logic [IN_W-1:0] sample_y;
  logic [IN_W-1:0] sample_z;
  modport source(output valid, sample_x, sample_y, sample_z, input ready);
  modport sink(input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface rvr_out_if;
  import rvr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] unit_x;
  logic signed [OUT_W-1:0] unit_y;
  logic signed [OUT_W-1:0] unit_z;
  modport source(output valid, unit_x, unit_y, unit_z, input ready);
  modport sink(input valid, unit_x, unit_y, unit_z, output ready);
endinterface
`default_nettype wire

// File: design/rvr_front.sv
`default_nettype none
module rvr_front #(
  parameter int SB = 16,
  parameter int OF = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          three_d,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rvr_pkg::IN_W-1:0]      raw [rvr_pkg::LANES],
  output rvr_pkg::rvr_ctl_t                  ctl_out,
  input  wire logic                          rdy_dn,
  output logic [2*SB-1:0]                    s_out,
  output logic [2*SB+2*OF+2:0]               r_out [rvr_pkg::LANES],
  output logic                               neg_out [rvr_pkg::LANES]
);
  import rvr_pkg::*;

  localparam int SW = 2 * SB;
  localparam int RW = 2 * SB + 2 * OF + 3;
  localparam logic [SB-1:0] FULL = '1;
  localparam logic [SW+1:0] LIM = (SW + 2)'(FULL) * (SW + 2)'(FULL);

  // Stage A: centered magnitudes squared.
  rvr_ctl_t       ctl_a;
  logic [SW-1:0]  sq_a  [LANES];
  logic           neg_a [LANES];
  logic           rdy_a;
  logic           rdy_b;
  logic [SB-1:0]  smp   [LANES];
  logic [SB:0]    dbl   [LANES];
  logic [SB-1:0]  mag   [LANES];
  logic [SW+1:0]  sum;
  logic           accept;

  assign rdy_b    = !ctl_out.valid || rdy_dn;
  assign rdy_a    = !ctl_a.valid || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      smp[k] = SB'(raw[k]);
      dbl[k] = {smp[k], 1'b0};
      if (dbl[k] >= {1'b0, FULL}) begin
        mag[k] = SB'(dbl[k] - {1'b0, FULL});
      end else begin
        mag[k] = SB'({1'b0, FULL} - dbl[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (rdy_a) begin
      ctl_a.valid   <= in_valid;
      ctl_a.three_d <= three_d;
    end
    if (rdy_a) begin
      for (int k = 0; k < LANES; k++) begin
        sq_a[k]  <= SW'(mag[k]) * SW'(mag[k]);
        neg_a[k] <= dbl[k] < {1'b0, FULL};
      end
    end
  end

  // Stage B: norm, acceptance window, and the scaled target per lane.
  always_comb begin
    sum = (SW + 2)'(sq_a[0]) + (SW + 2)'(sq_a[1]);
    if (ctl_a.three_d) begin
      sum = sum + (SW + 2)'(sq_a[2]);
    end
    accept = ({sum, 2'b00} >= {2'b00, LIM}) && (sum <= LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (rdy_b) begin
      ctl_out.valid   <= ctl_a.valid && accept;
      ctl_out.three_d <= ctl_a.three_d;
    end
    if (rdy_b) begin
      s_out <= SW'(sum);
      for (int k = 0; k < LANES; k++) begin
        r_out[k]   <= RW'(sq_a[k]) << (2 * OF);
        neg_out[k] <= neg_a[k];
      end
    end
  end
endmodule
`default_nettype wire

// File: design/rvr_cell.sv
`default_nettype none
module rvr_cell #(
  parameter int SB  = 16,
  parameter int OF  = 15,
  parameter int BIT = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rvr_pkg::rvr_ctl_t       ctl_in,
  output logic                         rdy_up,
  input  wire logic [2*SB-1:0]         s_in,
  input  wire logic [2*SB+2*OF+2:0]    r_in   [rvr_pkg::LANES],
  input  wire logic [2*SB+OF:0]        ms_in  [rvr_pkg::LANES],
  input  wire logic [OF:0]             m_in   [rvr_pkg::LANES],
  input  wire logic                    neg_in [rvr_pkg::LANES],
  output rvr_pkg::rvr_ctl_t            ctl_out,
  input  wire logic                    rdy_dn,
  output logic [2*SB-1:0]              s_out,
  output logic [2*SB+2*OF+2:0]         r_out   [rvr_pkg::LANES],
  output logic [2*SB+OF:0]             ms_out  [rvr_pkg::LANES],
  output logic [OF:0]                  m_out   [rvr_pkg::LANES],
  output logic                         neg_out [rvr_pkg::LANES]
);
  import rvr_pkg::*;

  localparam int RW = 2 * SB + 2 * OF + 3;
  localparam int MW = 2 * SB + OF + 1;

  // Trying bit BIT of m: (m + 2^b)^2*S - m^2*S = (m*S << (b+1)) + (S << 2b).
  // r holds c^2*2^(2F) - m^2*S and ms holds m*S, so no multiplier is needed.
  logic [RW-1:0] d    [LANES];
  logic          take [LANES];

  assign rdy_up = !ctl_out.valid || rdy_dn;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      d[k]    = (RW'(ms_in[k]) << (BIT + 1)) + (RW'(s_in) << (2 * BIT));
      take[k] = d[k] <= r_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (rdy_up) begin
      ctl_out <= ctl_in;
    end
    if (rdy_up) begin
      s_out <= s_in;
      for (int k = 0; k < LANES; k++) begin
        neg_out[k] <= neg_in[k];
        if (take[k]) begin
          r_out[k]  <= r_in[k] - d[k];
          ms_out[k] <= ms_in[k] + (MW'(s_in) << BIT);
          m_out[k]  <= m_in[k] | ((OF + 1)'(1) << BIT);
        end else begin
          r_out[k]  <= r_in[k];
          ms_out[k] <= ms_in[k];
          m_out[k]  <= m_in[k];
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/random_unit_vector_rejection_core.sv
`default_nettype none
// Random unit vector by rejection sampling.
// The samples channel takes one word of three raw uniform samples per
// cycle while samples.ready is high. Each sample is centered to
// 2s - (2^SAMPLE_BITS - 1); a candidate whose squared norm lies outside a
// quarter to one of full scale squared is dropped and gives no word on
// the units channel. An accepted candidate gives one word of signed Q1.15
// components, truncated toward zero, with unit_z zero in two-dimensional
// mode. The pipeline has two front stages (squares, then norm and window
// check), one cell per result bit, and the output register. Throughput is
// one word per cycle while the receiver does not stall.
// Each cell of the chain settles one bit of all three magnitudes with one
// add and compare per lane, and every stage has its own valid bit, so bubbles
// from rejected candidates are squeezed out when the receiver stalls and
// the samples channel keeps accepting until the chain is full.
// cfg_write loads three_d from cfg_data; write it only while
// idle. Reset empties the chain and sets three-dimensional mode.
module random_unit_vector_rejection_core #(
  parameter int SAMPLE_BITS   = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write,
  input  wire logic  cfg_data,
  rvr_in_if.sink     samples,
  rvr_out_if.source  units
);
  import rvr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int OF = OUT_FRAC_BITS;
  localparam int SW = 2 * SB;
  localparam int RW = 2 * SB + 2 * OF + 3;
  localparam int MW = 2 * SB + OF + 1;
  localparam int NC = OF + 1;

  logic            three_d;
  logic [IN_W-1:0] raw [LANES];

  rvr_ctl_t        ctl [NC+1];
  logic            rdy [NC+1];
  logic [SW-1:0]   s_c [NC+1];
  logic [RW-1:0]   r_c [NC+1][LANES];
  logic [MW-1:0]   ms_c [NC+1][LANES];
  logic [OF:0]     m_c [NC+1][LANES];
  logic            neg_c [NC+1][LANES];

  logic            rdy_o;
  logic [OF-1:0]   sat [LANES];
  logic [OUT_W-1:0] val [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b1;
    end else if (cfg_write) begin
      three_d <= cfg_data;
    end
  end

  assign raw[0] = samples.sample_x;
  assign raw[1] = samples.sample_y;
  assign raw[2] = samples.sample_z;

  rvr_front #(.SB(SB), .OF(OF)) u_front (
    .clk(clk), .rst(rst), .three_d(three_d),
    .in_valid(samples.valid), .in_ready(samples.ready), .raw(raw),
    .ctl_out(ctl[0]), .rdy_dn(rdy[0]), .s_out(s_c[0]), .r_out(r_c[0]),
    .neg_out(neg_c[0])
  );

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ms_c[0][k] = '0;
      m_c[0][k]  = '0;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rvr_cell #(.SB(SB), .OF(OF), .BIT(OF - i)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(ctl[i]), .rdy_up(rdy[i]), .s_in(s_c[i]), .r_in(r_c[i]),
      .ms_in(ms_c[i]), .m_in(m_c[i]), .neg_in(neg_c[i]),
      .ctl_out(ctl[i+1]), .rdy_dn(rdy[i+1]), .s_out(s_c[i+1]),
      .r_out(r_c[i+1]), .ms_out(ms_c[i+1]), .m_out(m_c[i+1]),
      .neg_out(neg_c[i+1])
    );
  end

  // Output register: saturate an exact unit magnitude, apply the sign.
  assign rdy_o   = !units.valid || units.ready;
  assign rdy[NC] = rdy_o;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sat[k] = m_c[NC][k][OF] ? '1 : m_c[NC][k][OF-1:0];
      val[k] = neg_c[NC][k] ? OUT_W'(-OUT_W'(sat[k])) : OUT_W'(sat[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units.valid <= 1'b0;
    end else if (rdy_o) begin
      units.valid <= ctl[NC].valid;
    end
    if (rdy_o) begin
      units.unit_x <= val[0];
      units.unit_y <= val[1];
      units.unit_z <= ctl[NC].three_d ? val[2] : '0;
    end
  end
endmodule
`default_nettype wire

// File: design/rvr_checker.sv
`default_nettype none
module rvr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] unit_x,
  input wire logic [15:0] unit_y,
  input wire logic [15:0] unit_z
);
  // A stalled result word stays valid with unit_x and unit_y unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y))
    else $error("result word changed while stalled");

  // Reset empties the chain, so nothing comes out right after it.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word right after reset");

  // Magnitudes saturate below full scale.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_x != 16'h8000 && unit_y != 16'h8000 && unit_z != 16'h8000)
    else $error("component outside the Q1.15 range");

  // An empty output register always frees the chain for a new sample word.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(!out_valid) && $past(!in_valid) |-> in_ready)
    else $error("sample channel stalled with an idle output");
endmodule

bind random_unit_vector_rejection_core rvr_checker u_rvr_checker (
  .clk(clk), .rst(rst),
  .in_valid(samples.valid), .in_ready(samples.ready),
  .out_valid(units.valid), .out_ready(units.ready),
  .unit_x(units.unit_x), .unit_y(units.unit_y), .unit_z(units.unit_z)
);
`default_nettype wire
